// ----- hdl/sqt_pkg.sv -----
// ----------------------------------------------------------------------------
// sqt_pkg
// Shared widths, codes and control types of the sleep queue timer.
// ----------------------------------------------------------------------------
package sqt_pkg;

    // Queue size and the width of the fill count that can hold it.
    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Field widths of the command and result transactions.
    localparam int CMD_W  = 2;
    localparam int TID_W  = 16;
    localparam int TICK_W = 32;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;

    // Command codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_TAKE   = 2'd2
    } t_cmd;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_NONE = 2'd2,
        ST_NULL = 2'd3
    } t_status;

    // Controller states.
    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // Latch the incoming transaction.
        logic execute;   // Apply the latched command and load the result.
    } t_dp_ctl;

endpackage

// ----- hdl/sqt_cmd_if.sv -----
// ----------------------------------------------------------------------------
// sqt_cmd_if
// Command channel: valid/ready handshake with the queue command payload.
// ----------------------------------------------------------------------------
interface sqt_cmd_if;
    import sqt_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [TID_W-1:0]  thread_id;
    logic [TICK_W-1:0] delay_ticks;

    modport source (output valid, cmd, thread_id, delay_ticks, input ready);
    modport sink   (input valid, cmd, thread_id, delay_ticks, output ready);
endinterface

// ----- hdl/sqt_res_if.sv -----
// ----------------------------------------------------------------------------
// sqt_res_if
// Result channel: valid/ready handshake with the queue result payload.
// ----------------------------------------------------------------------------
interface sqt_res_if;
    import sqt_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [TID_W-1:0]  woken_thread;
    logic [OCC_W-1:0]  occupancy;

    modport source (output valid, status, woken_thread, occupancy, input ready);
    modport sink   (input valid, status, woken_thread, occupancy, output ready);
endinterface

// ----- hdl/sqt_ctrl.sv -----
// ----------------------------------------------------------------------------
// sqt_ctrl
// Controller: accepts one command transaction, runs it once the result
// register is free, and tracks the result handshake.
// ----------------------------------------------------------------------------
module sqt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output sqt_pkg::t_dp_ctl o_ctl
);
    import sqt_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_slot_free;

    // State and result-valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        w_slot_free = !r_out_valid || i_out_ready;
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        o_ctl       = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_slot_free) begin
                    o_ctl.execute = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- hdl/sqt_datapath.sv -----
// ----------------------------------------------------------------------------
// sqt_datapath
// Sorted row of queue cells with the command register and result register.
// Every cell compares, shifts and decrements on its own in one step.
// ----------------------------------------------------------------------------
module sqt_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sqt_pkg::t_dp_ctl            i_ctl,
    input  logic [sqt_pkg::CMD_W-1:0]   i_cmd,
    input  logic [sqt_pkg::TID_W-1:0]   i_thread_id,
    input  logic [sqt_pkg::TICK_W-1:0]  i_delay_ticks,
    output logic [sqt_pkg::STAT_W-1:0]  o_status,
    output logic [sqt_pkg::TID_W-1:0]   o_woken_thread,
    output logic [sqt_pkg::OCC_W-1:0]   o_occupancy
);
    import sqt_pkg::*;

    // Latched command transaction.
    logic [CMD_W-1:0]  r_cmd;
    logic [TID_W-1:0]  r_tid;
    logic [TICK_W-1:0] r_delay;

    // Queue cells, head at index zero, and the fill count.
    logic [TID_W-1:0]  r_thr [QUEUE_DEPTH];
    logic [TICK_W-1:0] r_rem [QUEUE_DEPTH];
    logic [TID_W-1:0]  n_thr [QUEUE_DEPTH];
    logic [TICK_W-1:0] n_rem [QUEUE_DEPTH];
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;

    // Result register.
    logic [STAT_W-1:0] r_status;
    logic [TID_W-1:0]  r_woken;
    logic [STAT_W-1:0] n_status;
    logic [TID_W-1:0]  n_woken;

    // Per-cell flag: the cell is occupied and does not sleep longer than the new entry.
    logic [QUEUE_DEPTH-1:0] w_le;
    logic                   w_full;

    // Capture the command transaction.
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd   <= i_cmd;
            r_tid   <= i_thread_id;
            r_delay <= i_delay_ticks;
        end
    end

    // Cell comparisons against the new delay.
    always_comb begin
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            w_le[k] = (CNT_W'(k) < r_count) && (r_rem[k] <= r_delay);
        end
        w_full = (r_count == CNT_W'(QUEUE_DEPTH));
    end

    // Next cell contents, count and result for the latched command.
    always_comb begin
        n_thr    = r_thr;
        n_rem    = r_rem;
        n_count  = r_count;
        n_status = ST_OK;
        n_woken  = '0;
        case (r_cmd)
            CMD_INSERT: begin
                if (r_tid == '0) begin
                    n_status = ST_NULL;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    // Cells past the insert point move up one place.
                    for (int k = 0; k < QUEUE_DEPTH; k++) begin
                        if (!w_le[k]) begin
                            if (k == 0 || w_le[(k == 0) ? 0 : k - 1]) begin
                                n_thr[k] = r_tid;
                                n_rem[k] = r_delay;
                            end else begin
                                n_thr[k] = r_thr[(k == 0) ? 0 : k - 1];
                                n_rem[k] = r_rem[(k == 0) ? 0 : k - 1];
                            end
                        end
                    end
                    n_count = r_count + 1'b1;
                end
            end
            CMD_TICK: begin
                // Saturating decrement in every cell.
                for (int k = 0; k < QUEUE_DEPTH; k++) begin
                    if (r_rem[k] != '0) begin
                        n_rem[k] = r_rem[k] - 1'b1;
                    end
                end
            end
            CMD_TAKE: begin
                if (r_count == '0 || r_rem[0] != '0) begin
                    n_status = ST_NONE;
                end else begin
                    // Pop the head and move every cell down one place.
                    n_woken = r_thr[0];
                    for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
                        n_thr[k] = r_thr[k + 1];
                        n_rem[k] = r_rem[k + 1];
                    end
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // Queue cells and result payload.
    always_ff @(posedge i_clk) begin
        if (i_ctl.execute) begin
            r_thr    <= n_thr;
            r_rem    <= n_rem;
            r_status <= n_status;
            r_woken  <= n_woken;
        end
    end

    // Fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.execute) begin
            r_count <= n_count;
        end
    end

    assign o_status       = r_status;
    assign o_woken_thread = r_woken;
    assign o_occupancy    = OCC_W'(r_count);

endmodule

// ----- hdl/sleep_queue_timer.sv -----
// ----------------------------------------------------------------------------
// sleep_queue_timer
// Sleep queue of blocked threads kept sorted by remaining ticks.
//
//   Channel    Direction  Payload
//   i_cmd_ch   in         cmd, thread_id, delay_ticks
//   o_res_ch   out        status, woken_thread, occupancy
//
// Every command is first captured and then applied in a single step in which
// all queue cells compare, shift or decrement together. A new command is
// taken only once the previous one has been applied.
// Reset clears the fill count and the handshake state; cell contents are not
// cleared. A stalled result holds in its register; the next command is still
// captured and then waits until that result has been taken.
// ----------------------------------------------------------------------------
module sleep_queue_timer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sqt_cmd_if.sink   i_cmd_ch,
    sqt_res_if.source o_res_ch
);
    import sqt_pkg::*;

    t_dp_ctl w_ctl;

    // Sequencing of each transaction.
    sqt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd_ch.valid),
        .o_in_ready  (i_cmd_ch.ready),
        .i_out_ready (o_res_ch.ready),
        .o_out_valid (o_res_ch.valid),
        .o_ctl       (w_ctl)
    );

    // Queue cells and result register.
    sqt_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl),
        .i_cmd          (i_cmd_ch.cmd),
        .i_thread_id    (i_cmd_ch.thread_id),
        .i_delay_ticks  (i_cmd_ch.delay_ticks),
        .o_status       (o_res_ch.status),
        .o_woken_thread (o_res_ch.woken_thread),
        .o_occupancy    (o_res_ch.occupancy)
    );

endmodule

// ----- hdl/sqt_checker.sv -----
// ----------------------------------------------------------------------------
// sqt_checker
// Port-level checks of the sleep queue timer, bound to the top level.
// ----------------------------------------------------------------------------
module sqt_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [sqt_pkg::STAT_W-1:0]  i_status,
    input  logic [sqt_pkg::TID_W-1:0]   i_woken_thread,
    input  logic [sqt_pkg::OCC_W-1:0]   i_occupancy
);
    import sqt_pkg::*;

    // A pending result stays until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn before it was taken");

    // The block works on one transaction at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("command taken while the previous one is in progress");

    // Only a successful take reports a thread.
    a_woken_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != ST_OK) |-> (i_woken_thread == '0))
        else $error("thread reported on a failed command");

    // A full rejection comes only with a full queue.
    a_full_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_FULL) |-> (i_occupancy == OCC_W'(QUEUE_DEPTH)))
        else $error("queue full reported with free entries");

endmodule

bind sleep_queue_timer sqt_checker u_sqt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_cmd_ch.valid),
    .i_in_ready     (i_cmd_ch.ready),
    .i_out_valid    (o_res_ch.valid),
    .i_out_ready    (o_res_ch.ready),
    .i_status       (o_res_ch.status),
    .i_woken_thread (o_res_ch.woken_thread),
    .i_occupancy    (o_res_ch.occupancy)
);

// ----- test/tb_sleep_queue_timer.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sleep_queue_timer
// Self-checking bench for the sleep queue timer. A driver feeds insert, tick
// and take commands from a backlog, with random gaps and result stalls. A
// predictor keeps its own sorted sleep queue and checks every result in order.
// ----------------------------------------------------------------------------
module tb_sleep_queue_timer;
    import sqt_pkg::*;

    // Command code that the block does not use and must answer as a no-op.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    // Number of fully random delays in the random part; such entries almost
    // never expire, so they are kept few to leave room for the others.
    localparam int LONG_SLEEPERS = 6;
    localparam int RANDOM_ITEMS  = 1500;
    localparam int PHASE_LEN     = 32;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [TID_W-1:0]  tid;
        logic [TICK_W-1:0] ticks;
    } t_sleep_cmd;

    typedef struct {
        t_status          status;
        logic [TID_W-1:0] woken;
        logic [OCC_W-1:0] occ;
    } t_sleep_result;

    logic i_clk;
    logic i_rst_n;

    sqt_cmd_if cmd_ch ();
    sqt_res_if res_ch ();

    sleep_queue_timer u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd_ch (cmd_ch),
        .o_res_ch (res_ch)
    );

    // Predicted queue contents, head first.
    logic [TID_W-1:0]  sleeper_tid   [QUEUE_DEPTH];
    logic [TICK_W-1:0] sleeper_ticks [QUEUE_DEPTH];
    int                sleeper_count = 0;

    t_sleep_cmd    cmd_backlog [$];
    t_sleep_result results_due [$];
    int            mismatch_count = 0;

    // Handshake bookkeeping between the edge-sampled monitor and the drivers.
    logic       cmd_fired = 1'b0;
    logic       res_fired = 1'b0;
    logic       cmd_busy = 1'b0;
    logic       cmd_no_idle = 1'b0;
    logic       res_no_stall = 1'b0;
    int         cmd_gap = 0;
    int         res_stall = 0;
    t_sleep_cmd cmd_cur;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Known values on every input before the first edge.
    initial begin
        i_rst_n            = 1'b0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.cmd         = '0;
        cmd_ch.thread_id   = '0;
        cmd_ch.delay_ticks = '0;
        res_ch.ready       = 1'b0;
    end

    // Hard stop in case the block hangs.
    initial begin
        #2_000_000;
        $display("sleep_queue_timer test failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Applies one command to the predicted queue and returns its result.
    function automatic t_sleep_result apply_sleep_cmd(input t_sleep_cmd c);
        t_sleep_result r;
        int            pos;
        r.status = ST_OK;
        r.woken  = '0;
        case (c.cmd)
            CMD_INSERT: begin
                if (c.tid == '0) begin
                    r.status = ST_NULL;
                end else if (sleeper_count >= QUEUE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    // Equal times keep arrival order: skip past them.
                    pos = 0;
                    while (pos < sleeper_count && sleeper_ticks[pos] <= c.ticks)
                        pos++;
                    for (int k = sleeper_count; k > pos; k--) begin
                        sleeper_tid[k]   = sleeper_tid[k-1];
                        sleeper_ticks[k] = sleeper_ticks[k-1];
                    end
                    sleeper_tid[pos]   = c.tid;
                    sleeper_ticks[pos] = c.ticks;
                    sleeper_count++;
                end
            end
            CMD_TICK: begin
                for (int k = 0; k < sleeper_count; k++)
                    if (sleeper_ticks[k] != '0)
                        sleeper_ticks[k]--;
            end
            CMD_TAKE: begin
                if (sleeper_count == 0 || sleeper_ticks[0] != '0) begin
                    r.status = ST_NONE;
                end else begin
                    r.woken = sleeper_tid[0];
                    for (int k = 1; k < sleeper_count; k++) begin
                        sleeper_tid[k-1]   = sleeper_tid[k];
                        sleeper_ticks[k-1] = sleeper_ticks[k];
                    end
                    sleeper_count--;
                end
            end
            default: ;
        endcase
        r.occ = sleeper_count[OCC_W-1:0];
        return r;
    endfunction

    function automatic void queue_cmd(input logic [CMD_W-1:0] cmd,
                                      input logic [TID_W-1:0] tid,
                                      input logic [TICK_W-1:0] ticks);
        t_sleep_cmd c;
        c.cmd   = cmd;
        c.tid   = tid;
        c.ticks = ticks;
        cmd_backlog.push_back(c);
    endfunction

    // Command driver: presents one backlog entry at a time, changing on the
    // falling edge, with a random gap after each accepted transaction.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (cmd_busy && cmd_fired) begin
                cmd_busy = 1'b0;
                if ($urandom_range(0, 63) == 0)
                    cmd_no_idle = ~cmd_no_idle;
                cmd_gap = cmd_no_idle ? 0 : $urandom_range(0, 4);
            end
            if (!cmd_busy) begin
                if (cmd_gap != 0) begin
                    cmd_gap--;
                end else if (cmd_backlog.size() != 0) begin
                    cmd_cur  = cmd_backlog.pop_front();
                    cmd_busy = 1'b1;
                end
            end
        end
        cmd_ch.valid       <= cmd_busy;
        cmd_ch.cmd         <= cmd_busy ? cmd_cur.cmd : CMD_W'($urandom);
        cmd_ch.thread_id   <= cmd_busy ? cmd_cur.tid : TID_W'($urandom);
        cmd_ch.delay_ticks <= cmd_busy ? cmd_cur.ticks : TICK_W'($urandom);
    end

    // Result ready: after each accepted result, stall for a random time.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (res_fired) begin
                if ($urandom_range(0, 63) == 0)
                    res_no_stall = ~res_no_stall;
                res_stall = res_no_stall ? 0 : $urandom_range(0, 4);
            end else if (res_stall != 0) begin
                res_stall--;
            end
        end
        res_ch.ready <= i_rst_n && (res_stall == 0);
    end

    // Monitor: predicts on each accepted command and checks each accepted
    // result against the oldest prediction.
    always @(posedge i_clk) begin
        t_sleep_cmd    c;
        t_sleep_result want;
        cmd_fired <= i_rst_n && cmd_ch.valid && cmd_ch.ready;
        res_fired <= i_rst_n && res_ch.valid && res_ch.ready;
        if (i_rst_n && cmd_ch.valid && cmd_ch.ready) begin
            c.cmd   = cmd_ch.cmd;
            c.tid   = cmd_ch.thread_id;
            c.ticks = cmd_ch.delay_ticks;
            results_due.push_back(apply_sleep_cmd(c));
        end
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (results_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result: status %0d woken %0h occ %0d",
                                          res_ch.status, res_ch.woken_thread,
                                          res_ch.occupancy));
            end else begin
                want = results_due.pop_front();
                if (res_ch.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              res_ch.status, want.status));
                if (res_ch.woken_thread !== want.woken)
                    report_mismatch($sformatf("woken_thread %0h, expected %0h",
                                              res_ch.woken_thread, want.woken));
                if (res_ch.occupancy !== want.occ)
                    report_mismatch($sformatf("occupancy %0d, expected %0d",
                                              res_ch.occupancy, want.occ));
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int                mode;
        int                pick;
        int                long_left;
        logic [TICK_W-1:0] ticks;

        // Directed: empty queue cases, null thread, extremes, equal times,
        // take before expiry, fill to full, null on a full queue, tick at zero.
        queue_cmd(CMD_TAKE, 16'h0000, 32'h0000_0000);
        queue_cmd(CMD_TICK, 16'hFFFF, 32'hFFFF_FFFF);
        queue_cmd(CMD_UNUSED, 16'h5A5A, 32'h1234_5678);
        queue_cmd(CMD_INSERT, 16'h0000, 32'h0000_0005);
        queue_cmd(CMD_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
        queue_cmd(CMD_INSERT, 16'h0001, 32'h0000_0000);
        queue_cmd(CMD_INSERT, 16'h0002, 32'h0000_0000);
        queue_cmd(CMD_INSERT, 16'h0003, 32'h0000_0001);
        queue_cmd(CMD_TAKE, 16'h0000, 32'h0000_0000);
        queue_cmd(CMD_TAKE, 16'h0000, 32'h0000_0000);
        queue_cmd(CMD_TAKE, 16'h0000, 32'h0000_0000);
        queue_cmd(CMD_TICK, 16'h0000, 32'h0000_0000);
        queue_cmd(CMD_TAKE, 16'h0000, 32'h0000_0000);
        for (int k = 0; k < QUEUE_DEPTH - 1; k++)
            queue_cmd(CMD_INSERT, TID_W'(16 + k), TICK_W'(k % 5));
        queue_cmd(CMD_INSERT, 16'h1234, 32'h0000_0002);
        queue_cmd(CMD_INSERT, 16'h0000, 32'h0000_0002);
        queue_cmd(CMD_TICK, 16'h0000, 32'h0000_0000);

        // Random: phases that favor filling, draining or a mix, so the queue
        // both reaches full and empties again. Delays are mostly short.
        long_left = LONG_SLEEPERS;
        mode      = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % PHASE_LEN == 0)
                mode = $urandom_range(0, 2);
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 9) != 0) begin
                ticks = TICK_W'($urandom_range(0, 12));
            end else if (long_left > 0 && $urandom_range(0, 3) == 0) begin
                ticks = TICK_W'($urandom);
                long_left--;
            end else begin
                ticks = TICK_W'($urandom_range(0, 40));
            end
            if (pick < 3) begin
                queue_cmd(CMD_UNUSED, TID_W'($urandom), TICK_W'($urandom));
            end else if (pick < 6) begin
                queue_cmd(CMD_INSERT, 16'h0000, ticks);
            end else if (pick < (mode == 0 ? 75 : mode == 1 ? 16 : 45)) begin
                queue_cmd(CMD_INSERT, TID_W'($urandom_range(1, 16'hFFFF)), ticks);
            end else if (pick < (mode == 0 ? 85 : mode == 1 ? 50 : 72)) begin
                queue_cmd(CMD_TICK, TID_W'($urandom), TICK_W'($urandom));
            end else begin
                queue_cmd(CMD_TAKE, TID_W'($urandom), TICK_W'($urandom));
            end
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || cmd_busy || results_due.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("sleep_queue_timer test passed");
        else
            $display("sleep_queue_timer test failed");
        $finish;
    end

endmodule
